>>> rtl/abt_pkg.sv
// Package for the affine bounding box transform: widths, register indexes, payload types.
package abt_pkg;

	localparam int COORD_BITS   = 32;
	localparam int FRAC_BITS    = 16;
	localparam int CFG_IDX_BITS = 3;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_COEF_A   = 3'd0,
		REG_COEF_B   = 3'd1,
		REG_COEF_C   = 3'd2,
		REG_COEF_D   = 3'd3,
		REG_OFFSET_E = 3'd4,
		REG_OFFSET_F = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] rect_min_x;
		logic signed [COORD_BITS-1:0] rect_min_y;
		logic signed [COORD_BITS-1:0] rect_max_x;
		logic signed [COORD_BITS-1:0] rect_max_y;
	} rect_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] box_min_x;
		logic signed [COORD_BITS-1:0] box_min_y;
		logic signed [COORD_BITS-1:0] box_max_x;
		logic signed [COORD_BITS-1:0] box_max_y;
	} box_t;

endpackage

>>> rtl/affine_bbox_transform_core.sv
// Affine bounding box transform: four-stage pipeline mapping a rectangle to its transformed box.
//
// Usage
//   Input: a transaction is taken on each rising edge with start high and busy low.
//   busy never rises, so one rectangle is taken every cycle.
//   Output: done pulses for one cycle with the box on the result port, once the
//   rectangle has passed stages 1 to 4. One result per rectangle, in order.
//   Throughput: one rectangle per cycle, set by the eight registered 32x32
//   multipliers of the first stage, which all work on the same rectangle.
//   Stages: products, shift and per-term min/max, three-term sums, saturation.
//   Config: cfg_valid/cfg_ready write channel, cfg_ready always high; index 0..5
//   selects a, b, c, d, e, f, higher indexes are dropped. Write only while idle.
//   Reset: valid bits clear, matrix returns to identity with zero translation.
//   The receiver cannot hold results off; none is needed, nothing stalls.
module affine_bbox_transform_core #(
	parameter int FRAC_BITS = abt_pkg::FRAC_BITS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  abt_pkg::rect_t                      rect,
	output logic                                done,
	output abt_pkg::box_t                       box,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [abt_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [abt_pkg::COORD_BITS-1:0]      cfg_data
);
	import abt_pkg::*;

	localparam int CB   = COORD_BITS;
	localparam int PW   = 2 * CB;
	localparam int SW   = PW - FRAC_BITS;
	localparam int SUMW = SW + 2;
	localparam logic signed [CB-1:0]   ONE    = CB'(1) << FRAC_BITS;
	localparam logic signed [SUMW-1:0] SAT_HI = {{(SUMW-CB+1){1'b0}}, {(CB-1){1'b1}}};
	localparam logic signed [SUMW-1:0] SAT_LO = ~SAT_HI;

	logic signed [CB-1:0] coef_a_q, coef_b_q, coef_c_q, coef_d_q, offset_e_q, offset_f_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q   <= ONE;
			coef_b_q   <= '0;
			coef_c_q   <= '0;
			coef_d_q   <= ONE;
			offset_e_q <= '0;
			offset_f_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_COEF_A:   coef_a_q   <= cfg_data;
				REG_COEF_B:   coef_b_q   <= cfg_data;
				REG_COEF_C:   coef_c_q   <= cfg_data;
				REG_COEF_D:   coef_d_q   <= cfg_data;
				REG_OFFSET_E: offset_e_q <= cfg_data;
				REG_OFFSET_F: offset_f_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// stage 1: exact products, x terms use a and b, y terms use c and d
	logic                 v_s1, v_s2, v_s3, v_s4;
	logic signed [PW-1:0] ax0_s1, ax1_s1, bx0_s1, bx1_s1;
	logic signed [PW-1:0] cy0_s1, cy1_s1, dy0_s1, dy1_s1;
	logic signed [CB-1:0] off_e_s1, off_f_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ax0_s1   <= PW'(rect.rect_min_x) * PW'(coef_a_q);
		ax1_s1   <= PW'(rect.rect_max_x) * PW'(coef_a_q);
		bx0_s1   <= PW'(rect.rect_min_x) * PW'(coef_b_q);
		bx1_s1   <= PW'(rect.rect_max_x) * PW'(coef_b_q);
		cy0_s1   <= PW'(rect.rect_min_y) * PW'(coef_c_q);
		cy1_s1   <= PW'(rect.rect_max_y) * PW'(coef_c_q);
		dy0_s1   <= PW'(rect.rect_min_y) * PW'(coef_d_q);
		dy1_s1   <= PW'(rect.rect_max_y) * PW'(coef_d_q);
		off_e_s1 <= offset_e_q;
		off_f_s1 <= offset_f_q;
	end

	// stage 2: floor shift, then min/max per term; the sum is separable over corners
	logic signed [SW-1:0] ax0, ax1, bx0, bx1, cy0, cy1, dy0, dy1;
	logic signed [SW-1:0] ax_mn_s2, ax_mx_s2, bx_mn_s2, bx_mx_s2;
	logic signed [SW-1:0] cy_mn_s2, cy_mx_s2, dy_mn_s2, dy_mx_s2;
	logic signed [CB-1:0] off_e_s2, off_f_s2;

	assign ax0 = SW'(ax0_s1 >>> FRAC_BITS);
	assign ax1 = SW'(ax1_s1 >>> FRAC_BITS);
	assign bx0 = SW'(bx0_s1 >>> FRAC_BITS);
	assign bx1 = SW'(bx1_s1 >>> FRAC_BITS);
	assign cy0 = SW'(cy0_s1 >>> FRAC_BITS);
	assign cy1 = SW'(cy1_s1 >>> FRAC_BITS);
	assign dy0 = SW'(dy0_s1 >>> FRAC_BITS);
	assign dy1 = SW'(dy1_s1 >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		ax_mn_s2 <= (ax0 < ax1) ? ax0 : ax1;
		ax_mx_s2 <= (ax0 < ax1) ? ax1 : ax0;
		bx_mn_s2 <= (bx0 < bx1) ? bx0 : bx1;
		bx_mx_s2 <= (bx0 < bx1) ? bx1 : bx0;
		cy_mn_s2 <= (cy0 < cy1) ? cy0 : cy1;
		cy_mx_s2 <= (cy0 < cy1) ? cy1 : cy0;
		dy_mn_s2 <= (dy0 < dy1) ? dy0 : dy1;
		dy_mx_s2 <= (dy0 < dy1) ? dy1 : dy0;
		off_e_s2 <= off_e_s1;
		off_f_s2 <= off_f_s1;
	end

	// stage 3: exact three-term sums
	logic signed [SUMW-1:0] mnx_s3, mxx_s3, mny_s3, mxy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		mnx_s3 <= SUMW'(ax_mn_s2) + SUMW'(cy_mn_s2) + SUMW'(off_e_s2);
		mxx_s3 <= SUMW'(ax_mx_s2) + SUMW'(cy_mx_s2) + SUMW'(off_e_s2);
		mny_s3 <= SUMW'(bx_mn_s2) + SUMW'(dy_mn_s2) + SUMW'(off_f_s2);
		mxy_s3 <= SUMW'(bx_mx_s2) + SUMW'(dy_mx_s2) + SUMW'(off_f_s2);
	end

	// stage 4: saturate into the output register
	function automatic logic signed [CB-1:0] sat(input logic signed [SUMW-1:0] v);
		logic signed [CB-1:0] r;
		if (v > SAT_HI) begin
			r = CB'(SAT_HI);
		end else if (v < SAT_LO) begin
			r = CB'(SAT_LO);
		end else begin
			r = CB'(v);
		end
		return r;
	endfunction

	box_t box_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		box_s4.box_min_x <= sat(mnx_s3);
		box_s4.box_max_x <= sat(mxx_s3);
		box_s4.box_min_y <= sat(mny_s3);
		box_s4.box_max_y <= sat(mxy_s3);
	end

	assign done = v_s4;
	assign box  = box_s4;

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 4))
		else $error("result without a transaction four cycles earlier");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(start, 4) |-> !done)
		else $error("result appeared with no matching input");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (box.box_min_x <= box.box_max_x) && (box.box_min_y <= box.box_max_y))
		else $error("box min exceeds max");

	a_sat_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |=> (mnx_s3 <= mxx_s3 || !v_s3) && $past(mnx_s3 <= mxx_s3))
		else $error("sum min exceeds sum max");

endmodule
